// ===== hw/rtl/ctet_pkg.sv =====
// Package for the Cartesian tree / Euler tour block.
// Holds the sequencer state type and shared default sizes; no dependencies.
package ctet_pkg;

   localparam int MAX_ELEMENTS_DEF = 32;
   localparam int VALUE_BITS_DEF   = 32;
   localparam int SAMPLE_BITS      = 32;
   localparam int POS_BITS         = 5;
   localparam int DEPTH_BITS       = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_CMP,
      ST_PUSH,
      ST_ROOT_RD,
      ST_ROOT_SET,
      ST_TOUR
   } state_type;

endpackage

// ===== hw/rtl/ctet_cmp_unit.sv =====
// Shared two's complement signed compare used by the build stack pop loop.
// Stand-alone; no package dependencies.
module ctet_cmp_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic [VALUE_BITS-1:0] a_value,
   input  logic [VALUE_BITS-1:0] b_value,
   output logic                  a_gt_b
);

   logic [VALUE_BITS-1:0] a_key;
   logic [VALUE_BITS-1:0] b_key;
   logic [VALUE_BITS-1:0] sign_bit;

   // flip sign bit so unsigned compare follows two's complement order
   assign sign_bit = {1'b1, {(VALUE_BITS-1){1'b0}}};
   assign a_key    = a_value ^ sign_bit;
   assign b_key    = b_value ^ sign_bit;
   assign a_gt_b   = (a_key > b_key);

endmodule

// ===== hw/rtl/ctet_stack_mem.sv =====
// Build stack memory: one write port, one read port with registered data.
// Stand-alone; no package dependencies.
module ctet_stack_mem #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 37,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/cartesian_tree_euler_tour_top.sv =====
// Cartesian tree builder with Euler tour output; uses ctet_pkg, ctet_stack_mem, ctet_cmp_unit.
// Insert: busy while stack entries are inspected (a read state and a compare state each):
// the pops, plus one more unless the stack runs empty, then a push. Full: sample dropped.
// Final element: the root is fetched (ROOT_RD, ROOT_SET), then 2n-1 results, one per clock;
// the receiver cannot stall. Reset clears state, count, stack top and visited marks at once.
module cartesian_tree_euler_tour_top #(
   parameter int MAX_ELEMENTS = ctet_pkg::MAX_ELEMENTS_DEF,
   parameter int VALUE_BITS   = ctet_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ctet_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                             req_final_element,
   output logic                             rsp_valid,
   output logic [ctet_pkg::POS_BITS-1:0]    rsp_node_position,
   output logic [ctet_pkg::DEPTH_BITS-1:0]  rsp_tree_depth,
   output logic                             rsp_tour_end
);

   localparam int IDX_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int TOUR_W = $clog2(2 * MAX_ELEMENTS);
   localparam int MEM_W  = VALUE_BITS + IDX_W;
   localparam int PosW   = ctet_pkg::POS_BITS;
   localparam int DepthW = ctet_pkg::DEPTH_BITS;
   localparam logic [CNT_W-1:0]  MaxCnt   = CNT_W'(MAX_ELEMENTS);
   localparam logic [TOUR_W-1:0] TourLast = TOUR_W'(2 * MAX_ELEMENTS - 2);

   ctet_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      top_ff, top_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [IDX_W-1:0]      me_ff, me_in;
   logic                  final_ff, final_in;
   logic                  popped_ff, popped_in;
   logic [IDX_W-1:0]      pop_pos_ff, pop_pos_in;
   logic [CNT_W-1:0]      tsp_ff, tsp_in;
   logic [TOUR_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [MAX_ELEMENTS-1:0] visited_ff, visited_in;

   logic                  left_vld_ff  [MAX_ELEMENTS];
   logic [IDX_W-1:0]      left_pos_ff  [MAX_ELEMENTS];
   logic                  right_vld_ff [MAX_ELEMENTS];
   logic [IDX_W-1:0]      right_pos_ff [MAX_ELEMENTS];
   logic [IDX_W-1:0]      tstack_ff    [MAX_ELEMENTS];

   logic                  accept;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic                  mem_rd_en;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [MEM_W-1:0]      mem_rd_data;
   logic [VALUE_BITS-1:0] rd_key;
   logic [IDX_W-1:0]      rd_pos;
   logic                  cmp_gt;

   logic                  node_wr_en;
   logic                  link_wr_en;
   logic                  tstack_wr_en;
   logic [IDX_W-1:0]      tstack_wr_addr;
   logic [IDX_W-1:0]      tstack_wr_data;

   logic [CNT_W-1:0]      top_m1;
   logic [CNT_W-1:0]      tsp_m1;
   logic [IDX_W-1:0]      node;
   logic                  go_left;
   logic                  go_right;
   logic                  tour_last;

   assign accept = start && !busy;
   assign busy   = (state_ff != ctet_pkg::ST_IDLE);
   assign rd_key = mem_rd_data[MEM_W-1:IDX_W];
   assign rd_pos = mem_rd_data[IDX_W-1:0];
   assign top_m1 = top_ff - CNT_W'(1);
   assign tsp_m1 = tsp_ff - CNT_W'(1);
   assign node   = tstack_ff[tsp_m1[IDX_W-1:0]];

   assign go_left  = left_vld_ff[node] && !visited_ff[left_pos_ff[node]];
   assign go_right = right_vld_ff[node] && !visited_ff[right_pos_ff[node]];

   ctet_stack_mem #(
      .DEPTH  (MAX_ELEMENTS),
      .DATA_W (MEM_W),
      .ADDR_W (IDX_W)
   ) u_stack_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    ({key_ff, me_ff}),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   ctet_cmp_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_cmp_unit (
      .a_value (rd_key),
      .b_value (key_ff),
      .a_gt_b  (cmp_gt)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctet_pkg::ST_IDLE: begin
            if (accept) begin
               if (count_ff < MaxCnt) begin
                  state_in = (top_ff != '0) ? ctet_pkg::ST_POP_RD : ctet_pkg::ST_PUSH;
               end else if (req_final_element) begin
                  state_in = ctet_pkg::ST_ROOT_RD;
               end
            end
         end
         ctet_pkg::ST_POP_RD: begin
            state_in = ctet_pkg::ST_POP_CMP;
         end
         ctet_pkg::ST_POP_CMP: begin
            if (cmp_gt && (top_ff > CNT_W'(1))) begin
               state_in = ctet_pkg::ST_POP_RD;
            end else begin
               state_in = ctet_pkg::ST_PUSH;
            end
         end
         ctet_pkg::ST_PUSH: begin
            state_in = final_ff ? ctet_pkg::ST_ROOT_RD : ctet_pkg::ST_IDLE;
         end
         ctet_pkg::ST_ROOT_RD: begin
            state_in = ctet_pkg::ST_ROOT_SET;
         end
         ctet_pkg::ST_ROOT_SET: begin
            state_in = ctet_pkg::ST_TOUR;
         end
         ctet_pkg::ST_TOUR: begin
            if (tour_last) begin
               state_in = ctet_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctet_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control and outputs
   always_comb begin
      count_in       = count_ff;
      top_in         = top_ff;
      key_in         = key_ff;
      me_in          = me_ff;
      final_in       = final_ff;
      popped_in      = popped_ff;
      pop_pos_in     = pop_pos_ff;
      tsp_in         = tsp_ff;
      emit_cnt_in    = emit_cnt_ff;
      visited_in     = visited_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = top_ff[IDX_W-1:0];
      mem_rd_en      = 1'b0;
      mem_rd_addr    = top_m1[IDX_W-1:0];
      node_wr_en     = 1'b0;
      link_wr_en     = 1'b0;
      tstack_wr_en   = 1'b0;
      tstack_wr_addr = tsp_ff[IDX_W-1:0];
      tstack_wr_data = rd_pos;
      tour_last      = 1'b0;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         ctet_pkg::ST_IDLE: begin
            if (accept) begin
               final_in  = req_final_element;
               popped_in = 1'b0;
               key_in    = VALUE_BITS'($signed(req_sample_value));
               me_in     = count_ff[IDX_W-1:0];
            end
         end
         ctet_pkg::ST_POP_RD: begin
            mem_rd_en = 1'b1;
         end
         ctet_pkg::ST_POP_CMP: begin
            if (cmp_gt) begin
               popped_in  = 1'b1;
               pop_pos_in = rd_pos;
               top_in     = top_m1;
            end
         end
         ctet_pkg::ST_PUSH: begin
            mem_wr_en  = 1'b1;
            node_wr_en = 1'b1;
            link_wr_en = (top_ff != '0);
            top_in     = top_ff + CNT_W'(1);
            count_in   = count_ff + CNT_W'(1);
         end
         ctet_pkg::ST_ROOT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
         end
         ctet_pkg::ST_ROOT_SET: begin
            tstack_wr_en   = 1'b1;
            tstack_wr_addr = '0;
            visited_in[rd_pos] = 1'b1;
            tsp_in         = CNT_W'(1);
            emit_cnt_in    = '0;
         end
         ctet_pkg::ST_TOUR: begin
            rsp_valid   = 1'b1;
            emit_cnt_in = emit_cnt_ff + TOUR_W'(1);
            if (go_left) begin
               tstack_wr_en   = 1'b1;
               tstack_wr_data = left_pos_ff[node];
               visited_in[left_pos_ff[node]] = 1'b1;
               tsp_in         = tsp_ff + CNT_W'(1);
            end else if (go_right) begin
               tstack_wr_en   = 1'b1;
               tstack_wr_data = right_pos_ff[node];
               visited_in[right_pos_ff[node]] = 1'b1;
               tsp_in         = tsp_ff + CNT_W'(1);
            end else begin
               tsp_in = tsp_m1;
            end
            tour_last = (tsp_in == '0) || (emit_cnt_ff == TourLast);
            if (tour_last) begin
               visited_in = '0;
               count_in   = '0;
               top_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_node_position = PosW'(node);
   assign rsp_tree_depth    = DepthW'(tsp_m1[IDX_W-1:0]);
   assign rsp_tour_end      = rsp_valid && tour_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ctet_pkg::ST_IDLE;
         count_ff   <= '0;
         top_ff     <= '0;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         top_ff     <= top_in;
         visited_ff <= visited_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      me_ff       <= me_in;
      final_ff    <= final_in;
      popped_ff   <= popped_in;
      pop_pos_ff  <= pop_pos_in;
      tsp_ff      <= tsp_in;
      emit_cnt_ff <= emit_cnt_in;
   end

   // new node gets left child, empty right, parent's right link; tour stack write
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         left_vld_ff[me_ff]  <= popped_ff;
         left_pos_ff[me_ff]  <= pop_pos_ff;
         right_vld_ff[me_ff] <= 1'b0;
         right_pos_ff[me_ff] <= '0;
      end
      if (link_wr_en) begin
         right_vld_ff[rd_pos] <= 1'b1;
         right_pos_ff[rd_pos] <= me_ff;
      end
      if (tstack_wr_en) begin
         tstack_ff[tstack_wr_addr] <= tstack_wr_data;
      end
   end

`ifndef ASSERT_OFF
   a_end_at_root: assert property (@(posedge clock) disable iff (reset)
      rsp_tour_end |-> (rsp_valid && (rsp_tree_depth == '0)))
      else $error("tour ended away from the root");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= count_ff)
      else $error("build stack deeper than element count");

   a_tour_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tour_end |=> ((state_ff == ctet_pkg::ST_IDLE) && (count_ff == '0)
                        && (top_ff == '0) && (visited_ff == '0)))
      else $error("state not cleared after tour");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transfer while idle");
`endif

endmodule
